// ===== rtl/chained_range_remap_min_top_defines.svh =====
// Assertion macros for the range remapper RTL.
`ifndef CHAINED_RANGE_REMAP_MIN_TOP_DEFINES_SVH
`define CHAINED_RANGE_REMAP_MIN_TOP_DEFINES_SVH

`ifndef SYNTH
`define CRRM_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("%m: implication check failed");
`define CRRM_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("%m: next-cycle check failed");
`else
`define CRRM_ASSERT_IMP(label, clk, rst, a, b)
`define CRRM_ASSERT_NXT(label, clk, rst, a, b)
`endif

`endif

// ===== rtl/crrm_pkg.sv =====
// Types and constants of the chained range remapper.
`timescale 1ns / 1ps
package crrm_pkg;

  localparam int STAGES  = 8;
  localparam int ENTRIES = 64;
  localparam int WORD_W  = 32;

  localparam int STG_W  = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int SC_W   = $clog2(STAGES + 1);
  localparam int ENT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int DEPTH  = STAGES * ENTRIES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int SIU_W     = 4;
  localparam int STGIDX_W  = 3;
  localparam int S_TDATA_W = 136;
  localparam int M_TDATA_W = 64;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_MAP    = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POST
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] dest;
  } entry_t;

  typedef struct packed {
    func_t               func;
    logic [STGIDX_W-1:0] stage_index;
    logic [WORD_W-1:0]   dest_start;
    logic [WORD_W-1:0]   src_start;
    logic [WORD_W-1:0]   span_length;
    logic [WORD_W-1:0]   value_in;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] mapped_value;
    logic [WORD_W-1:0] running_min;
    logic              status;
  } res_t;

endpackage

// ===== rtl/chained_range_remap_min_top.sv =====
// Top level of the chained range remapper with running minimum.
`timescale 1ns / 1ps
// Usage:
//   s_* carries requests: tuser selects clear, append entry or map value;
//   tdata holds the entry or value. cfg_* writes stages_in_use; the user
//   must do so only while no request is in flight, unchecked by the block;
//   cfg_ready is always high. m_* returns one result per request: mapped
//   value and running minimum in tdata, the dropped-append flag in tuser.
// Sequencing:
//   Clear, append and unused codes: the result is held in the sequencer's
//   post state, then moves into the output register and m_tvalid rises.
//   Map: the sequencer scans every stage in use before the post state.
//   The entry table sits in one RAM with a single read port, scanned one
//   entry per cycle in stage order; a match ends that stage early.
//   One request is processed at a time; the next may be accepted while the
//   previous result waits in the output register.
// Reset:
//   Clears all stage counts, sets the minimum to all ones and stages_in_use
//   to zero. Table contents need no clearing pass.
// Backpressure:
//   A stalled m_tready holds the output register; a second finished result
//   then waits in the sequencer and s_tready stays low until it moves.
module chained_range_remap_min_top
  import crrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // stage_index[2:0], dest_start[34:3], src_start[66:35],
  // span_length[98:67], value_in[130:99], zero fill
  input  logic [S_TDATA_W-1:0] s_tdata,
  // func[1:0]
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // mapped_value[31:0], running_min[63:32]
  output logic [M_TDATA_W-1:0] m_tdata,
  // status[0]
  output logic [0:0]           m_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SIU_W-1:0]     cfg_data
);

  logic [SIU_W-1:0]  stages_in_use;
  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  entry_t            mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  entry_t            mem_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stages_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      stages_in_use <= cfg_data;
    end
  end

  assign req.func        = func_t'(s_tuser);
  assign req.stage_index = s_tdata[2:0];
  assign req.dest_start  = s_tdata[34:3];
  assign req.src_start   = s_tdata[66:35];
  assign req.span_length = s_tdata[98:67];
  assign req.value_in    = s_tdata[130:99];

  crrm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (s_tvalid),
    .req_ready    (s_tready),
    .req          (req),
    .stages_in_use(stages_in_use),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data)
  );

  crrm_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {res.running_min, res.mapped_value};
      m_tuser <= res.status;
    end
  end

endmodule

// ===== rtl/crrm_ram.sv =====
// Single-port-write, single-port-read synchronous RAM for range entries.
`timescale 1ns / 1ps
module crrm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 512
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/crrm_ctrl.sv =====
// Request sequencer: table fill, stage-by-stage range scan and running minimum.
`timescale 1ns / 1ps
`include "chained_range_remap_min_top_defines.svh"
module crrm_ctrl
  import crrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  input  logic [SIU_W-1:0]  stages_in_use,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  output logic              mem_wr_en,
  output logic [ADDR_W-1:0] mem_wr_addr,
  output entry_t            mem_wr_data,
  output logic              mem_rd_en,
  output logic [ADDR_W-1:0] mem_rd_addr,
  input  entry_t            mem_rd_data
);

  state_t            state, state_next;
  logic [SC_W-1:0]   k, k_next;
  logic [CNT_W-1:0]  i, i_next;
  logic              pend, pend_next;
  logic [WORD_W-1:0] v, v_next;
  logic [WORD_W-1:0] least, least_next;
  res_t              res_q, res_next;
  logic [CNT_W-1:0]  cnt [STAGES];

  logic [SC_W-1:0]   use_n;
  logic [STG_W-1:0]  cidx;
  logic [CNT_W-1:0]  cnt_sel;
  logic              stage_live;
  logic              more;
  logic [WORD_W-1:0] diff;
  logic              hit;
  logic              accept;
  logic              app_ok;
  logic              cnt_inc;
  logic              cnt_clr;

  always_comb begin
    if (32'(stages_in_use) > STAGES) begin
      use_n = SC_W'(STAGES);
    end else begin
      use_n = SC_W'(stages_in_use);
    end
  end

  assign cidx       = (state == ST_IDLE) ? STG_W'(req.stage_index) : k[STG_W-1:0];
  assign cnt_sel    = cnt[cidx];
  assign stage_live = (k < use_n);
  assign more       = stage_live && (i < cnt_sel);
  assign diff       = v - mem_rd_data.src;
  assign hit        = pend && (v >= mem_rd_data.src) && (diff < mem_rd_data.len);
  assign accept     = req_valid && req_ready;
  assign app_ok     = (32'(req.stage_index) < STAGES) && (32'(cnt_sel) < ENTRIES);

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_POST);
  assign res       = res_q;

  assign mem_wr_addr = ADDR_W'(ADDR_W'(cidx) * ADDR_W'(ENTRIES) + ADDR_W'(cnt_sel));
  assign mem_wr_data = '{len: req.span_length, src: req.src_start, dest: req.dest_start};
  assign mem_rd_addr = ADDR_W'(ADDR_W'(cidx) * ADDR_W'(ENTRIES) + ADDR_W'(i[ENT_W-1:0]));

  always_comb begin
    state_next = state;
    k_next     = k;
    i_next     = i;
    pend_next  = pend;
    v_next     = v;
    least_next = least;
    res_next   = res_q;
    mem_wr_en  = 1'b0;
    mem_rd_en  = 1'b0;
    cnt_inc    = 1'b0;
    cnt_clr    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_next = '{mapped_value: '0, running_min: least, status: 1'b0};
          state_next = ST_POST;
          case (req.func)
            FN_CLEAR: begin
              cnt_clr    = 1'b1;
              least_next = '1;
              res_next.running_min = '1;
            end
            FN_APPEND: begin
              if (app_ok) begin
                mem_wr_en = 1'b1;
                cnt_inc   = 1'b1;
              end else begin
                res_next.status = 1'b1;
              end
            end
            FN_MAP: begin
              v_next     = req.value_in;
              k_next     = '0;
              i_next     = '0;
              pend_next  = 1'b0;
              state_next = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          v_next    = mem_rd_data.dest + diff;
          k_next    = k + 1'b1;
          i_next    = '0;
          pend_next = 1'b0;
        end else if (more) begin
          mem_rd_en = 1'b1;
          i_next    = i + 1'b1;
          pend_next = 1'b1;
        end else if (pend) begin
          pend_next = 1'b0;
        end else if (stage_live) begin
          k_next = k + 1'b1;
          i_next = '0;
        end else begin
          least_next = (v < least) ? v : least;
          res_next   = '{mapped_value: v, running_min: (v < least) ? v : least,
                         status: 1'b0};
          state_next = ST_POST;
        end
      end
      ST_POST: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      least <= '1;
      for (int s = 0; s < STAGES; s++) begin
        cnt[s] <= '0;
      end
    end else begin
      state <= state_next;
      pend  <= pend_next;
      least <= least_next;
      if (cnt_clr) begin
        for (int s = 0; s < STAGES; s++) begin
          cnt[s] <= '0;
        end
      end else if (cnt_inc) begin
        cnt[cidx] <= cnt_sel + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    k     <= k_next;
    i     <= i_next;
    v     <= v_next;
    res_q <= res_next;
  end

  `CRRM_ASSERT_IMP(a_pend_in_scan, clk, rst, pend, state == ST_SCAN)
  `CRRM_ASSERT_IMP(a_write_in_idle, clk, rst, mem_wr_en, state == ST_IDLE && accept)
  `CRRM_ASSERT_IMP(a_stage_bound, clk, rst, state == ST_SCAN, k <= use_n)
  `CRRM_ASSERT_NXT(a_clear_min, clk, rst, accept && req.func == FN_CLEAR, least == '1)

endmodule
